// ----- rtl/core/vlrrc_pkg.sv -----
// Types and codes shared by the record ring producer block and its checker.
`timescale 1ns / 1ps
`default_nettype none

package vlrrc_pkg;

    localparam int LEN_W = 24;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [1:0] OP_RESERVE = 2'd0;
    localparam logic [1:0] OP_COMMIT  = 2'd1;
    localparam logic [1:0] OP_DISCARD = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_WRAP    = 2'd0;
    localparam logic [1:0] KIND_GRANT   = 2'd1;
    localparam logic [1:0] KIND_REFUSE  = 2'd2;
    localparam logic [1:0] KIND_FINISH  = 2'd3;

    // Refuse codes
    localparam logic [1:0] REFUSE_TOO_LONG  = 2'd0;
    localparam logic [1:0] REFUSE_FULL      = 2'd1;
    localparam logic [1:0] REFUSE_POS_FAULT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_ENABLED  = 2'd2;

    localparam logic [LEN_W-1:0] RING_LENGTH_RST   = 24'd65536;
    localparam logic [LEN_W-1:0] RESERVE_LIMIT_RST = 24'd65535;

    typedef struct packed {
        logic [1:0]       op;
        logic [LEN_W-1:0] record_length;
        logic [LEN_W-1:0] record_offset;
        logic [LEN_W-1:0] consumer_pos;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] header_offset;
        logic [LEN_W-1:0] payload_length;
        logic [3:0]       pad_bytes;
        logic [1:0]       refuse_code;
        logic             discarded;
        logic             wake;
        logic             last;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/core/variable_length_ring_reserve_commit.sv -----
// Producer side of a variable-length record ring: reserve, commit and discard.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one request per
//   transfer: a reserve, a commit or a discard, each with the consumer's current
//   position. Output channel (o_out_valid / i_out_stall / o_out_data) returns the
//   results: one per request, two when a reserve wraps (wrap marker at the old
//   position, then the grant at offset zero, marked last). Op code 3 gives no
//   result. Config port (i_cfg_we / i_cfg_index / i_cfg_data) is write-only and
//   must only be written while the block is idle.
//   Throughput: one request per cycle while results are taken at once; after a
//   wrap the next request waits for the second result. The request stage
//   registers the length-plus-header and, for a non-power-of-two alignment, its
//   alignment quotient; the second stage does the room check and updates the
//   producer position. Reset clears the producer position, restores the config
//   defaults and drops any queued request or result. When the receiver stalls,
//   the result holds and one further request may wait in the request stage;
//   then o_in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module variable_length_ring_reserve_commit
    import vlrrc_pkg::*;
#(
    parameter int HEADER_BYTES = 8,
    parameter int ALIGN_BYTES  = 16,
    parameter int POS_WIDTH    = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_W-1:0]     i_cfg_data
);

    localparam int CW        = ((POS_WIDTH > LEN_W) ? POS_WIDTH : LEN_W) + 2;
    localparam int XW        = LEN_W + 1;
    localparam int RMW       = $clog2(2 * ALIGN_BYTES + 1);
    localparam int ALIGN_LOG = $clog2(ALIGN_BYTES);
    localparam bit IS_POW2   = ((1 << ALIGN_LOG) == ALIGN_BYTES);

    // Configuration
    logic [LEN_W-1:0]     r_ring_length;
    logic [LEN_W-1:0]     r_reserve_limit;
    logic                 r_wake_enabled;

    // Producer position
    logic [POS_WIDTH-1:0] r_pp, n_pp;

    // Request stage
    logic                 r_s1_valid;
    t_in_item             r_s1;
    logic [XW-1:0]        r_s1_x, n_s1_x;
    logic [RMW-1:0]       s1_rem;
    logic                 s1_load;

    // Result registers
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;
    logic                 r_pend_valid, n_pend_valid;
    t_out_item            r_pend, n_pend;

    logic                 out_free;
    logic                 s2_fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s2_fire    = r_s1_valid && !r_pend_valid && out_free;
    assign s1_load    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_valid && !s2_fire;

    assign n_s1_x = XW'(i_in_data.record_length) + XW'(HEADER_BYTES);

    // Remainder of (length + header) modulo the alignment
    generate
        if (IS_POW2) begin : g_pow2
            assign s1_rem = RMW'(r_s1_x & XW'(ALIGN_BYTES - 1));
        end else begin : g_recip
            localparam int S  = XW + 7;
            localparam int MW = S - 1;
            localparam logic [63:0] RECIP64 = (64'd1 << S) / ALIGN_BYTES;
            localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];

            logic [XW+MW-1:0] prod;
            logic [XW-2:0]    r_s1_q;
            logic [XW-1:0]    q_times_a;
            logic [XW-1:0]    rem_raw;

            // Quotient estimate is exact or one low; fix with one subtract
            assign prod = (XW+MW)'(n_s1_x) * (XW+MW)'(RECIP);

            always_ff @(posedge i_clk) begin
                if (s1_load) begin
                    r_s1_q <= prod[XW+MW-1:S];
                end
            end

            assign q_times_a = XW'(r_s1_q) * XW'(ALIGN_BYTES);
            assign rem_raw   = r_s1_x - q_times_a;
            assign s1_rem    = (rem_raw >= XW'(ALIGN_BYTES))
                             ? RMW'(rem_raw - XW'(ALIGN_BYTES)) : RMW'(rem_raw);
        end
    endgenerate

    // Reserve evaluation
    logic [RMW-1:0] pad;
    logic [CW-1:0]  req_c, pp_c, cp_c, rl_c, rem_c, base_c;
    logic           pp_ge_cp, pos_fault, too_long, no_room, full, tail_fault, wrap;

    always_comb begin
        pad        = (s1_rem == '0) ? '0 : RMW'(ALIGN_BYTES) - s1_rem;
        req_c      = CW'(r_s1_x) + CW'(pad) + CW'(HEADER_BYTES);
        pp_c       = CW'(r_pp);
        cp_c       = CW'(r_s1.consumer_pos);
        rl_c       = CW'(r_ring_length);
        pp_ge_cp   = pp_c >= cp_c;
        rem_c      = pp_ge_cp ? (rl_c - pp_c) : (cp_c - pp_c);
        pos_fault  = pp_ge_cp ? (pp_c > rl_c) : (rem_c > rl_c);
        too_long   = r_s1.record_length > r_reserve_limit;
        no_room    = req_c > rem_c;
        full       = no_room && (!pp_ge_cp || (req_c > cp_c));
        tail_fault = no_room && !full && (rem_c < CW'(HEADER_BYTES));
        wrap       = no_room && !full && !tail_fault;
        base_c     = wrap ? '0 : pp_c;
    end

    // Results of the item in the request stage
    t_out_item res0, res1;
    logic      res0_v, res1_v;
    logic      pp_upd;

    always_comb begin
        res0   = '0;
        res1   = '0;
        res0_v = 1'b0;
        res1_v = 1'b0;
        pp_upd = 1'b0;
        unique case (r_s1.op) inside
            OP_COMMIT, OP_DISCARD: begin
                res0_v               = 1'b1;
                res0.kind            = KIND_FINISH;
                res0.header_offset   = r_s1.record_offset;
                res0.discarded       = (r_s1.op == OP_DISCARD);
                res0.wake            = r_wake_enabled
                                    && (r_s1.consumer_pos == r_s1.record_offset);
                res0.last            = 1'b1;
            end
            OP_RESERVE: begin
                res0_v = 1'b1;
                if (too_long) begin
                    res0.kind        = KIND_REFUSE;
                    res0.refuse_code = REFUSE_TOO_LONG;
                    res0.last        = 1'b1;
                end else if (pos_fault || tail_fault) begin
                    res0.kind        = KIND_REFUSE;
                    res0.refuse_code = REFUSE_POS_FAULT;
                    res0.last        = 1'b1;
                end else if (full) begin
                    res0.kind        = KIND_REFUSE;
                    res0.refuse_code = REFUSE_FULL;
                    res0.last        = 1'b1;
                end else if (wrap) begin
                    res0.kind           = KIND_WRAP;
                    res0.header_offset  = LEN_W'(r_pp);
                    res1_v              = 1'b1;
                    res1.kind           = KIND_GRANT;
                    res1.payload_length = r_s1.record_length;
                    res1.pad_bytes      = 4'(pad);
                    res1.last           = 1'b1;
                    pp_upd              = 1'b1;
                end else begin
                    res0.kind           = KIND_GRANT;
                    res0.header_offset  = LEN_W'(r_pp);
                    res0.payload_length = r_s1.record_length;
                    res0.pad_bytes      = 4'(pad);
                    res0.last           = 1'b1;
                    pp_upd              = 1'b1;
                end
            end
            default: begin
                // op 3: drop without result
            end
        endcase
    end

    // Advance the result registers
    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_pp         = r_pp;
        if (r_pend_valid && out_free) begin
            n_out_valid  = 1'b1;
            n_out        = r_pend;
            n_pend_valid = 1'b0;
        end else if (s2_fire) begin
            if (res0_v) begin
                n_out_valid = 1'b1;
                n_out       = res0;
            end
            if (res1_v) begin
                n_pend_valid = 1'b1;
                n_pend       = res1;
            end
            if (pp_upd) begin
                n_pp = POS_WIDTH'(base_c + CW'(r_s1_x) + CW'(pad));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_pend_valid    <= 1'b0;
            r_pp            <= '0;
            r_ring_length   <= RING_LENGTH_RST;
            r_reserve_limit <= RESERVE_LIMIT_RST;
            r_wake_enabled  <= 1'b0;
        end else begin
            r_s1_valid   <= s1_load || o_in_stall;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            r_pp         <= n_pp;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RING_LENGTH:   r_ring_length   <= i_cfg_data;
                    CFG_RESERVE_LIMIT: r_reserve_limit <= i_cfg_data;
                    CFG_WAKE_ENABLED:  r_wake_enabled  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1   <= i_in_data;
            r_s1_x <= n_s1_x;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/vlrrc_checker.sv -----
// Port-level checker for the record ring producer block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module vlrrc_checker
    import vlrrc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Transfer of a wrap marker is followed at once by the grant at offset zero
    a_wrap_then_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.kind == KIND_WRAP
        |=> o_out_valid && o_out_data.kind == KIND_GRANT
            && o_out_data.header_offset == '0 && o_out_data.last)
        else $error("wrap marker not followed by grant at zero");

    // Wrap marker is never the final result of a request
    a_wrap_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_WRAP |-> !o_out_data.last)
        else $error("wrap marker flagged last");

    // Refusals carry no position or length, and finish marks only on finishes
    a_refuse_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_FINISH
        |-> !o_out_data.discarded && !o_out_data.wake
            && (o_out_data.kind != KIND_REFUSE
                || (o_out_data.header_offset == '0
                    && o_out_data.payload_length == '0 && o_out_data.last)))
        else $error("malformed refuse or stray finish flags");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind variable_length_ring_reserve_commit vlrrc_checker u_vlrrc_checker (.*);

`default_nettype wire

// ----- tb/variable_length_ring_reserve_commit_tb.sv -----
// Self-checking testbench for the record ring producer: directed cases, then random traffic.
`timescale 1ns / 1ps
`default_nettype none

module variable_length_ring_reserve_commit_tb
    import vlrrc_pkg::*;
();

    localparam int HDR_BYTES     = 8;
    localparam int ALIGN         = 16;
    localparam int POS_W         = 24;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 5_000_000;

    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [LEN_W-1:0]     LEN_MAX    = 24'hFFFFFF;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data  = '0;

    // Predicted producer state and register copies
    logic [POS_W-1:0] prod_pos     = '0;
    logic [LEN_W-1:0] ring_len_reg = RING_LENGTH_RST;
    logic [LEN_W-1:0] limit_reg    = RESERVE_LIMIT_RST;
    logic             wake_en_reg  = 1'b0;

    t_out_item        pending_results[$];
    logic [LEN_W-1:0] open_records[$];
    int               fail_count  = 0;
    bit               valid_high  = 1'b0;
    bit               calm        = 1'b0;
    int unsigned      cycle_count = 0;

    variable_length_ring_reserve_commit #(
        .HEADER_BYTES(HDR_BYTES),
        .ALIGN_BYTES (ALIGN),
        .POS_WIDTH   (POS_W)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none at all while calm
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[7:0] == 8'd0) calm <= ($urandom_range(0, 3) == 0);
    end

    initial begin : out_stall_gen
        int run;
        forever begin
            run = pick_gap();
            if (run > 0) begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    function automatic void push_refusal(input logic [1:0] code);
        t_out_item r;
        r = '0;
        r.kind = KIND_REFUSE;
        r.refuse_code = code;
        r.last = 1'b1;
        pending_results.push_back(r);
    endfunction

    // Queue the results of one accepted request and advance the producer position
    function automatic void predict_ring_results(input t_in_item item);
        longint unsigned pp, cp, len, rem, req, pad;
        t_out_item r;
        pp = 64'(prod_pos);
        cp = 64'(item.consumer_pos);
        len = 64'(item.record_length);
        r = '0;
        r.last = 1'b1;
        if (item.op == OP_COMMIT || item.op == OP_DISCARD) begin
            r.kind = KIND_FINISH;
            r.header_offset = item.record_offset;
            r.discarded = (item.op == OP_DISCARD);
            r.wake = wake_en_reg && (item.consumer_pos == item.record_offset);
            pending_results.push_back(r);
            return;
        end
        if (item.op != OP_RESERVE) return;
        if (len > limit_reg) begin
            push_refusal(REFUSE_TOO_LONG);
            return;
        end
        if (pp >= cp) begin
            if (pp > ring_len_reg) begin
                push_refusal(REFUSE_POS_FAULT);
                return;
            end
            rem = 64'(ring_len_reg) - pp;
        end else begin
            rem = cp - pp;
            if (rem > ring_len_reg) begin
                push_refusal(REFUSE_POS_FAULT);
                return;
            end
        end
        req = (len + HDR_BYTES + ALIGN - 1) / ALIGN * ALIGN;
        pad = req - len - HDR_BYTES;
        // keep room for one spare header (a later wrap marker)
        req = req + HDR_BYTES;
        if (req > rem) begin
            if (pp < cp || req > cp) begin
                push_refusal(REFUSE_FULL);
                return;
            end
            if (rem < HDR_BYTES) begin
                push_refusal(REFUSE_POS_FAULT);
                return;
            end
            r.kind = KIND_WRAP;
            r.header_offset = LEN_W'(pp);
            r.last = 1'b0;
            pending_results.push_back(r);
            pp = 0;
        end
        r = '0;
        r.kind = KIND_GRANT;
        r.header_offset = LEN_W'(pp);
        r.payload_length = LEN_W'(len);
        r.pad_bytes = pad[3:0];
        r.last = 1'b1;
        pending_results.push_back(r);
        open_records.push_back(LEN_W'(pp));
        if (open_records.size() > 16) void'(open_records.pop_front());
        prod_pos = POS_W'(pp + req - HDR_BYTES);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d, header_offset %0d", got.kind, got.header_offset);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind", 32'(want.kind), 32'(got.kind));
        compare_field("header_offset", 32'(want.header_offset), 32'(got.header_offset));
        compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
        compare_field("pad_bytes", 32'(want.pad_bytes), 32'(got.pad_bytes));
        compare_field("refuse_code", 32'(want.refuse_code), 32'(got.refuse_code));
        compare_field("discarded", 32'(want.discarded), 32'(got.discarded));
        compare_field("wake", 32'(want.wake), 32'(got.wake));
        compare_field("last", 32'(want.last), 32'(got.last));
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) check_result(out_data);
    end

    function automatic t_in_item make_item(input logic [1:0] op,
                                           input logic [LEN_W-1:0] len,
                                           input logic [LEN_W-1:0] roff,
                                           input logic [LEN_W-1:0] cp);
        t_in_item it;
        it.op = op;
        it.record_length = len;
        it.record_offset = roff;
        it.consumer_pos = cp;
        return it;
    endfunction

    // Hold valid across back-to-back transfers; drop it only before a gap
    task automatic send_request(input t_in_item item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            if (valid_high) begin
                in_valid <= 1'b0;
                valid_high = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_data <= item;
        if (!valid_high) begin
            in_valid <= 1'b1;
            valid_high = 1'b1;
        end
        do @(posedge clk); while (in_stall !== 1'b0);
        predict_ring_results(item);
    endtask

    task automatic drain_results();
        if (valid_high) begin
            in_valid <= 1'b0;
            valid_high = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_RING_LENGTH:   ring_len_reg = value;
            CFG_RESERVE_LIMIT: limit_reg = value;
            CFG_WAKE_ENABLED:  wake_en_reg = value[0];
            default: ;
        endcase
    endtask

    function automatic t_in_item random_reserve();
        t_in_item it;
        int unsigned pick;
        it = make_item(OP_RESERVE, '0, LEN_W'($urandom), '0);
        pick = $urandom_range(0, 99);
        if (pick < 65)
            it.record_length = LEN_W'($urandom_range(0, (limit_reg < 600) ? limit_reg : 600));
        else if (pick < 80) it.record_length = LEN_W'($urandom_range(0, limit_reg));
        else if (pick < 90) it.record_length = LEN_W'(limit_reg + $urandom_range(1, 16));
        else it.record_length = LEN_W'($urandom);
        // consumer at, behind or ahead of the producer, now and then anywhere
        pick = $urandom_range(0, 99);
        if (pick < 35) it.consumer_pos = prod_pos;
        else if (pick < 70) it.consumer_pos = LEN_W'($urandom_range(0, prod_pos));
        else if (pick < 90 && prod_pos < ring_len_reg)
            it.consumer_pos = LEN_W'($urandom_range(prod_pos + 1, ring_len_reg));
        else it.consumer_pos = LEN_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item random_finish(input logic [1:0] op);
        t_in_item it;
        it = make_item(op, LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
        if (open_records.size() > 0 && $urandom_range(0, 3) != 0)
            it.record_offset = open_records[$urandom_range(0, open_records.size() - 1)];
        if ($urandom_range(0, 9) < 4) it.consumer_pos = it.record_offset;
        return it;
    endfunction

    task automatic test_reset_defaults();
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, 24'd0));
        send_request(make_item(OP_RESERVE, 24'd8, 24'd0, 24'd0));
        send_request(make_item(OP_RESERVE, RESERVE_LIMIT_RST, 24'd0, 24'd0));
        send_request(make_item(OP_RESERVE, RESERVE_LIMIT_RST + 24'd1, 24'd0, 24'd0));
        send_request(make_item(OP_RESERVE, LEN_MAX, 24'd0, 24'd0));
        // consumer more than a whole ring ahead
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, prod_pos + RING_LENGTH_RST + 24'd1));
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, LEN_MAX));
        send_request(make_item(OP_COMMIT, 24'd0, 24'd16, 24'd16));
        send_request(make_item(OP_DISCARD, LEN_MAX, 24'd0, 24'd7));
        send_request(make_item(OP_UNUSED, LEN_MAX, LEN_MAX, LEN_MAX));
    endtask

    task automatic test_wrap_and_faults();
        drain_results();
        write_register(CFG_WAKE_ENABLED, 24'd1);
        write_register(CFG_RESERVE_LIMIT, LEN_MAX);
        write_register(CFG_RING_LENGTH, LEN_MAX);
        send_request(make_item(OP_RESERVE, 24'hF00000, 24'd0, prod_pos));
        // leave a tail too short for the smallest record: wrap to the front
        drain_results();
        write_register(CFG_RING_LENGTH, prod_pos + 24'd16);
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, prod_pos));
        send_request(make_item(OP_RESERVE, 24'd40, 24'd0, prod_pos));
        // producer past the end of a shrunken ring
        drain_results();
        write_register(CFG_RING_LENGTH, prod_pos - 24'd4);
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, prod_pos));
        // tail shorter than one header, then full from both sides
        drain_results();
        write_register(CFG_RING_LENGTH, prod_pos + 24'd6);
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, 24'd30));
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, 24'd10));
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, prod_pos + 24'd10));
        drain_results();
        write_register(CFG_RING_LENGTH, 24'd0);
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, prod_pos + 24'd36));
        send_request(make_item(OP_COMMIT, 24'd0, 24'd16, 24'd16));
        send_request(make_item(OP_DISCARD, 24'd0, 24'd16, 24'd17));
        drain_results();
        write_register(CFG_RESERVE_LIMIT, 24'd0);
        write_register(CFG_RING_LENGTH, LEN_MAX);
        write_register(CFG_WAKE_ENABLED, 24'd0);
        send_request(make_item(OP_RESERVE, 24'd0, 24'd0, prod_pos));
        send_request(make_item(OP_RESERVE, 24'd1, 24'd0, prod_pos));
        send_request(make_item(OP_COMMIT, 24'd0, 24'd16, 24'd16));
        drain_results();
        write_register(CFG_UNUSED, LEN_MAX);
    endtask

    task automatic test_random_traffic();
        logic [LEN_W-1:0] ring_len;
        int unsigned pick;
        int n;
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            case (ph)
                0: ring_len = LEN_W'($urandom_range(256, 1024));
                1: ring_len = LEN_W'($urandom_range(1024, 4096));
                2: ring_len = RING_LENGTH_RST;
                3: ring_len = LEN_W'($urandom_range(96, 300));
                default: ring_len = LEN_W'($urandom_range(256, 8192));
            endcase
            // never start a phase with the producer outside the ring
            if (ring_len < prod_pos + 64) ring_len = LEN_W'(prod_pos + 64);
            write_register(CFG_RING_LENGTH, ring_len);
            write_register(CFG_RESERVE_LIMIT, (ph == 0) ? LEN_MAX
                           : LEN_W'($urandom_range(ring_len / 8, ring_len / 2)));
            write_register(CFG_WAKE_ENABLED, LEN_W'($urandom));
            n = 0;
            while (n < 85) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    send_request(make_item(OP_UNUSED, LEN_W'($urandom), LEN_W'($urandom),
                                           LEN_W'($urandom)));
                end else begin
                    if (pick < 65) send_request(random_reserve());
                    else if (pick < 83) send_request(random_finish(OP_COMMIT));
                    else send_request(random_finish(OP_DISCARD));
                    n++;
                end
                if ((ph == 1 && n == 40) || $urandom_range(0, 59) == 0) drain_results();
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_wrap_and_faults();
        test_random_traffic();
        drain_results();
        if (fail_count == 0) begin
            $display("variable_length_ring_reserve_commit_tb passed");
        end else begin
            $display("variable_length_ring_reserve_commit_tb failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("variable_length_ring_reserve_commit_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
